// ----- rtl/wlrm_pkg.sv -----
// ----------------------------------------------------------------------------
// wlrm_pkg
// Shared types and constants of the windowed link rate monitor.
// ----------------------------------------------------------------------------
package wlrm_pkg;

  localparam int unsigned SizeW  = 17;
  localparam int unsigned StampW = 32;
  localparam int unsigned SpeedW = 40;
  localparam int unsigned TotalW = 48;
  localparam int unsigned SumW   = 23;   // 64 x 17-bit sizes
  localparam int unsigned NumW   = 43;   // sum * 1000000
  localparam logic [19:0] USEC_PER_SEC = 20'd1000000;
  localparam logic [SpeedW-1:0] SPEED_MAX = {SpeedW{1'b1}};
  localparam logic [TotalW-1:0] TOTAL_MAX = {TotalW{1'b1}};

  // Divide by three as multiply by ceil(2^35 / 3), split into two 17-bit halves
  localparam int unsigned Recip3W      = 17;
  localparam logic [Recip3W-1:0] RECIP3_HI = 17'h15555;
  localparam logic [Recip3W-1:0] RECIP3_LO = 17'h0AAAB;
  localparam int unsigned RECIP3_SHIFT = 35;

  localparam logic MODE_SEND = 1'b0;
  localparam logic MODE_RECV = 1'b1;

  typedef struct packed {
    logic        mode;
    logic [15:0] payload_len;
    logic [7:0]  header_len;
    logic [31:0] packet_stamp;
    logic [31:0] now_stamp;
    logic [31:0] trip_time;
  } in_item_t;

  typedef struct packed {
    logic              direction;
    logic [SpeedW-1:0] speed_bytes;
    logic [TotalW-1:0] total_bytes;
    logic [31:0]       trip_max_smoothed;
  } out_item_t;

endpackage

// ----- rtl/wlrm_div.sv -----
// ----------------------------------------------------------------------------
// wlrm_div
// Restoring bit-serial divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlrm_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [wlrm_pkg::NumW-1:0]     num,
  input  logic [31:0]                   den,
  output logic                          busy,
  output logic                          done,
  output logic [wlrm_pkg::NumW-1:0]     quo
);
  localparam int unsigned CntW = 6;

  logic [wlrm_pkg::NumW-1:0] q_r;
  logic [32:0]               rem_r;
  logic [31:0]               den_r;
  logic [CntW-1:0]           cnt_r;
  logic                      busy_r, done_r;
  logic [32:0]               trial;
  logic [33:0]               diffv;

  assign trial = {rem_r[31:0], q_r[wlrm_pkg::NumW-1]};
  assign diffv = {1'b0, trial} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CntW'(wlrm_pkg::NumW - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      if (!diffv[33]) begin
        rem_r <= diffv[32:0];
        q_r   <= {q_r[wlrm_pkg::NumW-2:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r   <= {q_r[wlrm_pkg::NumW-2:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quo  = q_r;
endmodule

// ----- rtl/windowed_link_rate_monitor.sv -----
// ----------------------------------------------------------------------------
// windowed_link_rate_monitor
// Sliding-window throughput meter for send and receive packet events.
// ----------------------------------------------------------------------------
// Usage: each in_ transaction is one packet event (mode 0 send, 1 receive).
// The block writes size, stamp and (send) trip time into that direction's
// ring, then walks the ring through a registered-read memory to form the
// size sum, least nonzero stamp and largest trip time. A 43-step bit-serial
// divider then yields bytes per second; one out_ transaction follows.
// Flow: the item passes through the ring scan, a totals step, a trip
// smoothing step, the divider (skipped when the time span is zero) and
// the output step. One item is in flight at a time: in_ready stays low
// from acceptance until the result is loaded into the output register.
// Reset: sync active-low rst_n clears control state, totals, rates and the
// smoothed trip time, and starts a clearing pass that zeroes both rings;
// in_ready stays low during it.
// Stall: the result is held in an output register and never altered while
// waiting; a new transaction may be accepted meanwhile, and its result is
// held back in the output state until the register is free.
// ----------------------------------------------------------------------------
module windowed_link_rate_monitor #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  wlrm_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output wlrm_pkg::out_item_t  out_data
);
  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned AddrW = SlotW + 1;            // direction + slot
  localparam int unsigned EntW  = wlrm_pkg::SizeW + 64;
  localparam logic [SlotW-1:0] LAST = SlotW'(WINDOW - 1);
  localparam int unsigned ProdW = 34 + wlrm_pkg::Recip3W;

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_SCAN = 3'd2;
  localparam logic [2:0] ST_TRIP = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;
  localparam logic [2:0] ST_SMTH = 3'd6;

  // Ring memory: {size, stamp, trip} per entry, both directions
  logic [EntW-1:0] ring_mem [2*WINDOW];
  logic [EntW-1:0] rd_data_r;
  logic            we;
  logic [AddrW-1:0] wr_addr, rd_addr;
  logic [EntW-1:0] wr_data;

  logic [2:0]       state_r;
  logic [SlotW-1:0] clr_r, scan_r, send_slot_r, recv_slot_r;
  logic             clr_half_r;
  logic             rd_vld_r, last_rd_r;
  wlrm_pkg::in_item_t item_r;
  logic [wlrm_pkg::SumW-1:0] sum_r;
  logic [31:0]      low_r, max_r, trip_sm_r;
  logic [wlrm_pkg::SpeedW-1:0] send_rate_r, recv_rate_r;
  logic [wlrm_pkg::TotalW-1:0] send_tot_r, recv_tot_r;
  logic             out_valid_r;
  wlrm_pkg::out_item_t out_r;
  logic [ProdW-1:0] trip_ph_r, trip_pl_r;

  logic [wlrm_pkg::SizeW-1:0] in_size, rd_size;
  logic [31:0] rd_stamp, rd_trip, diff;
  logic [wlrm_pkg::TotalW:0] tot_sum;
  logic [wlrm_pkg::TotalW-1:0] tot_nxt;
  logic [wlrm_pkg::NumW-1:0] num, quo;
  logic [33:0] trip_acc;
  logic [ProdW+wlrm_pkg::Recip3W-1:0] trip_prod;
  logic div_start, div_busy, div_done;
  logic [wlrm_pkg::SpeedW-1:0] speed_sat;
  logic accept;
  logic out_load;

  assign accept  = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);
  assign in_size = wlrm_pkg::SizeW'(in_data.payload_len) + wlrm_pkg::SizeW'(in_data.header_len);
  assign rd_size  = rd_data_r[EntW-1 -: wlrm_pkg::SizeW];
  assign rd_stamp = rd_data_r[63:32];
  assign rd_trip  = rd_data_r[31:0];

  // Write on accept (new entry) or during the clearing pass
  always_comb begin
    we      = 1'b0;
    wr_addr = {clr_half_r, clr_r};
    wr_data = '0;
    if (state_r == ST_CLR) begin
      we = 1'b1;
    end else if (accept) begin
      we = 1'b1;
      wr_addr = {in_data.mode,
                 (in_data.mode == wlrm_pkg::MODE_SEND) ? send_slot_r : recv_slot_r};
      wr_data = {in_size, in_data.packet_stamp,
                 (in_data.mode == wlrm_pkg::MODE_SEND) ? in_data.trip_time : 32'd0};
    end
  end

  assign rd_addr = {item_r.mode, scan_r};

  // Read happens after the write of the same entry, so no forwarding needed
  always_ff @(posedge clk) begin
    if (we) begin
      ring_mem[AddrW'(wr_addr[AddrW-1] ? (WINDOW + 32'(wr_addr[SlotW-1:0]))
                                       : 32'(wr_addr[SlotW-1:0]))] <= wr_data;
    end
    rd_data_r <= ring_mem[AddrW'(rd_addr[AddrW-1] ? (WINDOW + 32'(rd_addr[SlotW-1:0]))
                                                  : 32'(rd_addr[SlotW-1:0]))];
  end

  assign tot_sum = {1'b0, (item_r.mode == wlrm_pkg::MODE_SEND) ? send_tot_r : recv_tot_r}
                 + (wlrm_pkg::TotalW+1)'(wlrm_pkg::SizeW'(item_r.payload_len)
                                        + wlrm_pkg::SizeW'(item_r.header_len));
  assign tot_nxt = tot_sum[wlrm_pkg::TotalW] ? wlrm_pkg::TOTAL_MAX
                                             : tot_sum[wlrm_pkg::TotalW-1:0];
  assign diff    = item_r.now_stamp - low_r;
  assign num     = wlrm_pkg::NumW'(sum_r) * wlrm_pkg::NumW'(wlrm_pkg::USEC_PER_SEC);
  assign trip_acc = {2'b00, trip_sm_r} + {1'b0, max_r, 1'b0};
  // Recombine the two partial products of the reciprocal multiplication
  assign trip_prod = {trip_ph_r, {wlrm_pkg::Recip3W{1'b0}}}
                   + {{wlrm_pkg::Recip3W{1'b0}}, trip_pl_r};
  assign speed_sat = (|quo[wlrm_pkg::NumW-1:wlrm_pkg::SpeedW]) ? wlrm_pkg::SPEED_MAX
                                                             : quo[wlrm_pkg::SpeedW-1:0];

  assign div_start = (state_r == ST_SMTH) && (diff != 32'd0);
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || out_ready);

  wlrm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (num),
    .den   (diff),
    .busy  (div_busy),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      clr_half_r  <= 1'b0;
      scan_r      <= '0;
      rd_vld_r    <= 1'b0;
      last_rd_r   <= 1'b0;
      send_slot_r <= '0;
      recv_slot_r <= '0;
      trip_sm_r   <= '0;
      send_rate_r <= '0;
      recv_rate_r <= '0;
      send_tot_r  <= '0;
      recv_tot_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_CLR: begin
          if (clr_r == LAST) begin
            clr_r <= '0;
            clr_half_r <= 1'b1;
            if (clr_half_r) state_r <= ST_IDLE;
          end else begin
            clr_r <= clr_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            item_r <= in_data;
            if (in_data.mode == wlrm_pkg::MODE_SEND)
              send_slot_r <= (send_slot_r == LAST) ? '0 : send_slot_r + 1'b1;
            else
              recv_slot_r <= (recv_slot_r == LAST) ? '0 : recv_slot_r + 1'b1;
            scan_r    <= '0;
            rd_vld_r  <= 1'b0;
            last_rd_r <= 1'b0;
            sum_r     <= '0;
            low_r     <= 32'hFFFF_FFFF;
            max_r     <= '0;
            state_r   <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          // Issue reads; accumulate the read data, which arrives in the following cycle
          rd_vld_r  <= !last_rd_r;
          if (scan_r == LAST) last_rd_r <= 1'b1;
          else scan_r <= scan_r + 1'b1;
          if (rd_vld_r) begin
            sum_r <= sum_r + wlrm_pkg::SumW'(rd_size);
            if (rd_stamp != 32'd0 && rd_stamp < low_r) low_r <= rd_stamp;
            if (rd_trip > max_r) max_r <= rd_trip;
          end
          if (last_rd_r && rd_vld_r) state_r <= ST_TRIP;
        end
        ST_TRIP: begin
          if (item_r.mode == wlrm_pkg::MODE_SEND) begin
            send_tot_r <= tot_nxt;
          end else begin
            recv_tot_r <= tot_nxt;
          end
          // Split the divide by three into two narrow partial products
          trip_ph_r <= {{wlrm_pkg::Recip3W{1'b0}}, trip_acc}
                     * {34'd0, wlrm_pkg::RECIP3_HI};
          trip_pl_r <= {{wlrm_pkg::Recip3W{1'b0}}, trip_acc}
                     * {34'd0, wlrm_pkg::RECIP3_LO};
          state_r <= ST_SMTH;
        end
        ST_SMTH: begin
          if (item_r.mode == wlrm_pkg::MODE_SEND)
            trip_sm_r <= trip_prod[wlrm_pkg::RECIP3_SHIFT +: 32];
          if (diff != 32'd0) begin
            state_r <= ST_DIV;
          end else begin
            if (item_r.mode == wlrm_pkg::MODE_RECV) recv_rate_r <= '0;
            state_r <= ST_OUT;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if (item_r.mode == wlrm_pkg::MODE_SEND) send_rate_r <= speed_sat;
            else recv_rate_r <= speed_sat;
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          // Hold the new result until the output register is free
          if (out_load) begin
            out_r.direction   <= item_r.mode;
            out_r.speed_bytes <= (item_r.mode == wlrm_pkg::MODE_SEND) ? send_rate_r
                                                                     : recv_rate_r;
            out_r.total_bytes <= (item_r.mode == wlrm_pkg::MODE_SEND) ? send_tot_r
                                                                     : recv_tot_r;
            out_r.trip_max_smoothed <= trip_sm_r;
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Clearing pass covers the receive half when clr_half_r is set
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Held result must not change while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(out_r))
    else $error("result changed while stalled");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready)
    else $error("ready outside idle");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");
  a_slots: assert property (@(posedge clk) disable iff (!rst_n)
    send_slot_r <= LAST && recv_slot_r <= LAST)
    else $error("ring pointer out of range");
endmodule
